>>> rtl/ntpdt_pkg.sv
`timescale 1ns / 1ps

package ntpdt_pkg;

    // Field widths
    localparam int SECS_W   = 32;
    localparam int ZONE_W   = 8;
    localparam int YEAR_W   = 11;
    localparam int YEAR_CW  = 12;   // internal year count, wide enough for late epochs
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAYS_W   = 16;   // whole days since epoch, below 2^16
    localparam int CNT_W    = 4;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;

    localparam int DEFAULT_EPOCH_YEAR = 1900;
    localparam int ZONE_COUNT         = 50;

    // Time constants
    localparam logic [SECS_W-1:0] DAY_SEC  = 32'd86400;
    localparam logic [SECS_W-1:0] HOUR_SEC = 32'd3600;
    localparam logic [SECS_W-1:0] MIN_SEC  = 32'd60;

    // Division step counts (highest quotient bit index)
    localparam logic [CNT_W-1:0] DAY_TOP  = 4'd15;
    localparam logic [CNT_W-1:0] HOUR_TOP = 4'd4;
    localparam logic [CNT_W-1:0] MIN_TOP  = 4'd5;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_YEAR,
        ST_MONTH,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } state_t;

    // Signed zone offset in seconds, as a two's complement word
    function automatic logic [SECS_W-1:0] zone_offset(input logic [ZONE_W-1:0] code);
        logic signed [SECS_W-1:0] offs;
        offs = '0;
        case (code)
            8'd0:  offs = -32'sd43200;
            8'd1:  offs = -32'sd39600;
            8'd2:  offs = -32'sd36000;
            8'd3:  offs = -32'sd34200;
            8'd4:  offs = -32'sd32400;
            8'd5:  offs = -32'sd28800;
            8'd6:  offs = -32'sd28800;
            8'd7:  offs = -32'sd25200;
            8'd8:  offs = -32'sd25200;
            8'd9:  offs = -32'sd21600;
            8'd10: offs = -32'sd21600;
            8'd11: offs = -32'sd18000;
            8'd12: offs = -32'sd18000;
            8'd13: offs = -32'sd18000;
            8'd14: offs = -32'sd16200;
            8'd15: offs = -32'sd14400;
            8'd16: offs = -32'sd14400;
            8'd17: offs = -32'sd12600;
            8'd18: offs = -32'sd10800;
            8'd19: offs = -32'sd7200;
            8'd20: offs = -32'sd3600;
            8'd23: offs = 32'sd3600;
            8'd24: offs = 32'sd3600;
            8'd25: offs = 32'sd3600;
            8'd26: offs = 32'sd7200;
            8'd27: offs = 32'sd7200;
            8'd28: offs = 32'sd10800;
            8'd29: offs = 32'sd10800;
            8'd30: offs = 32'sd12600;
            8'd31: offs = 32'sd14400;
            8'd32: offs = 32'sd16200;
            8'd33: offs = 32'sd18000;
            8'd34: offs = 32'sd19800;
            8'd35: offs = 32'sd20700;
            8'd36: offs = 32'sd21600;
            8'd37: offs = 32'sd23400;
            8'd38: offs = 32'sd25200;
            8'd39: offs = 32'sd28800;
            8'd40: offs = 32'sd32400;
            8'd41: offs = 32'sd34200;
            8'd42: offs = 32'sd36000;
            8'd43: offs = 32'sd37800;
            8'd44: offs = 32'sd39600;
            8'd45: offs = 32'sd41400;
            8'd46: offs = 32'sd43200;
            8'd47: offs = 32'sd45900;
            8'd48: offs = 32'sd46800;
            8'd49: offs = 32'sd50400;
            default: offs = '0;
        endcase
        return offs;
    endfunction

    // Days in each month of a common year, January is code 0
    function automatic logic [SECS_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [SECS_W-1:0] d;
        d = 32'd31;
        case (m)
            4'd1:  d = 32'd28;
            4'd3:  d = 32'd30;
            4'd5:  d = 32'd30;
            4'd8:  d = 32'd30;
            4'd10: d = 32'd30;
            default: d = 32'd31;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/ntp_seconds_to_local_date_time.sv
`timescale 1ns / 1ps

// NTP seconds to local calendar date and time.
// Input stream (s_*): one transfer carries the 32-bit NTP seconds in s_tdata.
// Output stream (m_*): one transfer per input with UTC seconds, local seconds
// and the Gregorian year, month, day, hour, minute and second.
// Config: cfg_we writes cfg_wdata into the time zone code; write only while idle.
// Steps from input transfer to m_tvalid: day division, year scan, month scan,
// hour division, minute division and the output load. The zone offset is
// added as the item is taken. The year scan strips one year per cycle
// through the shared compare-subtract unit. s_tready is high only while the
// sequencer is idle, so one item is in work at a time. A finished result
// sits in the output register; the next item may be accepted and worked on
// while it waits, and the sequencer holds its new result until the receiver
// takes the old one.
// Reset (aresetn low, synchronous) returns to idle, drops any pending result
// and sets the zone code to 0 (UTC-12:00).
module ntp_seconds_to_local_date_time #(
    parameter int EPOCH_YEAR = ntpdt_pkg::DEFAULT_EPOCH_YEAR
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Zone code register
    input  logic                                cfg_we,
    input  logic [ntpdt_pkg::ZONE_W-1:0]        cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ntpdt_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] ntp_seconds
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] utc_seconds, [63:32] local_seconds, [74:64] year, [78:75] month,
    // [83:79] day, [88:84] hour, [94:89] minute, [100:95] second, [103:101] zero
    output logic [ntpdt_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import ntpdt_pkg::*;

    localparam logic [YEAR_CW-1:0] EPOCH_Y   = YEAR_CW'(EPOCH_YEAR);
    localparam logic [6:0]         EPOCH_M100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]         EPOCH_M400 = 9'(EPOCH_YEAR % 400);

    state_t state_reg, state_next;

    logic [ZONE_W-1:0]   time_zone_reg;
    logic [SECS_W-1:0]   utc_reg, utc_next;
    logic [SECS_W-1:0]   local_reg, local_next;
    logic [SECS_W-1:0]   acc_reg, acc_next;
    logic [DAYS_W-1:0]   days_reg, days_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [YEAR_CW-1:0]  year_reg, year_next;
    logic [6:0]          m100_reg, m100_next;
    logic [8:0]          m400_reg, m400_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [MINUTE_W-1:0] q_reg, q_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [SECS_W-1:0] op_a, op_b;
    logic [SECS_W:0]   diff;
    logic              ge;
    logic              leap;
    logic [SECS_W-1:0] ylen, mlen;
    logic              in_xfer;
    logic              out_load;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Leap year from running residues of the year count
    assign leap = (m400_reg == 9'd0) || ((m100_reg != 7'd0) && (year_reg[1:0] == 2'd0));
    assign ylen = leap ? 32'd366 : 32'd365;
    assign mlen = ((month_reg == MONTH_FEB) && leap) ? 32'd29 : month_days(month_reg);

    // Select operands for the shared compare-subtract unit
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_DAY: begin
                op_a = acc_reg;
                op_b = DAY_SEC << cnt_reg;
            end
            ST_YEAR: begin
                op_a = SECS_W'(days_reg);
                op_b = ylen;
            end
            ST_MONTH: begin
                op_a = SECS_W'(days_reg);
                op_b = mlen;
            end
            ST_HOUR: begin
                op_a = acc_reg;
                op_b = HOUR_SEC << cnt_reg;
            end
            ST_MIN: begin
                op_a = acc_reg;
                op_b = MIN_SEC << cnt_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign ge   = !diff[SECS_W];

    // Sequence the steps
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY: begin
                if (cnt_reg == '0) begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (!ge) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (!ge || month_reg == MONTH_DEC) begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates per step
    always_comb begin
        utc_next     = utc_reg;
        local_next   = local_reg;
        acc_next     = acc_reg;
        days_next    = days_reg;
        cnt_next     = cnt_reg;
        year_next    = year_reg;
        m100_next    = m100_reg;
        m400_next    = m400_reg;
        month_next   = month_reg;
        q_next       = q_reg;
        hour_next    = hour_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // Take the item and apply the zone offset
                if (in_xfer) begin
                    utc_next   = s_tdata[SECS_W-1:0];
                    local_next = s_tdata[SECS_W-1:0] + zone_offset(time_zone_reg);
                    acc_next   = s_tdata[SECS_W-1:0] + zone_offset(time_zone_reg);
                    days_next  = '0;
                    cnt_next   = DAY_TOP;
                    year_next  = EPOCH_Y;
                    m100_next  = EPOCH_M100;
                    m400_next  = EPOCH_M400;
                end
            end
            ST_DAY: begin
                // Restoring division by seconds per day
                if (ge) begin
                    acc_next = diff[SECS_W-1:0];
                end
                days_next = {days_reg[DAYS_W-2:0], ge};
                cnt_next  = cnt_reg - 4'd1;
            end
            ST_YEAR: begin
                // Strip whole years
                if (ge) begin
                    days_next = diff[DAYS_W-1:0];
                    year_next = year_reg + 12'd1;
                    m100_next = (m100_reg == 7'd99)  ? 7'd0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                end else begin
                    month_next = MONTH_JAN;
                end
            end
            ST_MONTH: begin
                // Strip whole months, stop at December
                if (ge && month_reg != MONTH_DEC) begin
                    days_next  = diff[DAYS_W-1:0];
                    month_next = month_reg + 4'd1;
                end else begin
                    cnt_next = HOUR_TOP;
                    q_next   = '0;
                end
            end
            ST_HOUR: begin
                // Restoring division of time of day by 3600
                if (ge) begin
                    acc_next = diff[SECS_W-1:0];
                end
                q_next   = {q_reg[MINUTE_W-2:0], ge};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    hour_next = {q_reg[HOUR_W-2:0], ge};
                    q_next    = '0;
                    cnt_next  = MIN_TOP;
                end
            end
            ST_MIN: begin
                // Restoring division of remaining seconds by 60
                if (ge) begin
                    acc_next = diff[SECS_W-1:0];
                end
                q_next   = {q_reg[MINUTE_W-2:0], ge};
                cnt_next = cnt_reg - 4'd1;
            end
            ST_DONE: begin
                // Load the output register once it is free
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000,
                                    acc_reg[SECOND_W-1:0],
                                    q_reg,
                                    hour_reg,
                                    DAY_W'(days_reg[DAY_W-1:0] + 5'd1),
                                    MONTH_W'(month_reg + 4'd1),
                                    year_reg[YEAR_W-1:0],
                                    local_reg,
                                    utc_reg};
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            time_zone_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                time_zone_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        utc_reg    <= utc_next;
        local_reg  <= local_next;
        acc_reg    <= acc_next;
        days_reg   <= days_next;
        cnt_reg    <= cnt_next;
        year_reg   <= year_next;
        m100_reg   <= m100_next;
        m400_reg   <= m400_next;
        month_reg  <= month_next;
        q_reg      <= q_next;
        hour_reg   <= hour_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> rtl/ntpdt_checker.sv
`timescale 1ns / 1ps

module ntpdt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ntpdt_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import ntpdt_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // After an input transfer the block is busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Month field stays in calendar range and day field is nonzero
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[78:75] != 4'd0) && (m_tdata[78:75] <= 4'd12)
                     && (m_tdata[83:79] != 5'd0))
        else $error("month or day out of range");

    // Hour, minute and second fields stay in clock range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[88:84] <= 5'd23) && (m_tdata[94:89] <= 6'd59)
                     && (m_tdata[100:95] <= 6'd59))
        else $error("time of day out of range");

endmodule

bind ntp_seconds_to_local_date_time ntpdt_checker u_ntpdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/ntp_seconds_to_local_date_time_tb.sv
`timescale 1ns / 1ps

module ntp_seconds_to_local_date_time_tb;

    import ntpdt_pkg::*;

    localparam int EPOCH_BASE     = DEFAULT_EPOCH_YEAR;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 200;

    // Zone codes used by name in the tests
    localparam logic [ZONE_W-1:0] ZONE_UTC_M1200 = 8'd0;
    localparam logic [ZONE_W-1:0] ZONE_UTC_A     = 8'd21;
    localparam logic [ZONE_W-1:0] ZONE_UTC_B     = 8'd22;
    localparam logic [ZONE_W-1:0] ZONE_UTC_P0545 = 8'd35;
    localparam logic [ZONE_W-1:0] ZONE_UTC_P1245 = 8'd47;
    localparam logic [ZONE_W-1:0] ZONE_UTC_P1400 = 8'd49;
    localparam logic [ZONE_W-1:0] ZONE_PAST_END  = 8'd50;
    localparam logic [ZONE_W-1:0] ZONE_TOP_CODE  = 8'd255;

    typedef struct packed {
        logic [SECS_W-1:0]   utc_s;
        logic [SECS_W-1:0]   local_s;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    mday;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [2:0]          pad;
    } date_time_t;

    // Zone shift in minutes, indexed by zone code
    int zone_minutes [0:49] = '{
        -720, -660, -600, -570, -540, -480, -480, -420, -420, -360,
        -360, -300, -300, -300, -270, -240, -240, -210, -180, -120,
        -60, 0, 0, 60, 60, 60, 120, 120, 180, 180,
        210, 240, 270, 300, 330, 345, 360, 390, 420, 480,
        540, 570, 600, 630, 660, 690, 720, 765, 780, 840
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [ZONE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [31:0] ntp_seconds
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // utc, local, year, month, day, hour, min, sec

    logic [ZONE_W-1:0]     zone_code = '0;
    date_time_t            pending_dates [$];
    int                    mismatch_count = 0;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    quiet_cycles = 0;

    logic                  in_xfer_n  = 1'b0;
    logic                  out_xfer_n = 1'b0;
    logic [OUT_DATA_W-1:0] out_data_n = '0;

    ntp_seconds_to_local_date_time #(
        .EPOCH_YEAR (EPOCH_BASE)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit has_feb29(input logic [31:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic logic [31:0] month_length(input logic [3:0] mon_idx,
                                                 input logic [31:0] y);
        case (mon_idx)
            4'd1:                      return has_feb29(y) ? 32'd29 : 32'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   return 32'd30;
            default:                   return 32'd31;
        endcase
    endfunction

    // Expected calendar breakdown of one timestamp under the given zone code
    function automatic date_time_t local_date_time(input logic [SECS_W-1:0] secs,
                                                   input logic [ZONE_W-1:0] zone);
        date_time_t  r;
        logic [31:0] loc, days, tod, yr, ylen, mlen;
        logic [3:0]  mon;
        int          shift;
        shift = 0;
        if (zone < ZONE_COUNT)
            shift = zone_minutes[zone] * SECS_PER_MIN;
        loc  = secs + shift;
        days = loc / SECS_PER_DAY;
        tod  = loc % SECS_PER_DAY;
        // walk whole years, then whole months
        yr   = EPOCH_BASE;
        ylen = has_feb29(yr) ? 32'd366 : 32'd365;
        while (days >= ylen) begin
            days = days - ylen;
            yr   = yr + 1;
            ylen = has_feb29(yr) ? 32'd366 : 32'd365;
        end
        mon  = 4'd0;
        mlen = month_length(mon, yr);
        while (mon < 4'd11 && days >= mlen) begin
            days = days - mlen;
            mon  = mon + 4'd1;
            mlen = month_length(mon, yr);
        end
        r.utc_s   = secs;
        r.local_s = loc;
        r.year    = yr[YEAR_W-1:0];
        r.month   = mon + 4'd1;
        r.mday    = days[DAY_W-1:0] + 5'd1;
        r.hour    = HOUR_W'(tod / SECS_PER_HOUR);
        r.minute  = MINUTE_W'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
        r.second  = SECOND_W'(tod % SECS_PER_MIN);
        r.pad     = '0;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want_v, want_v, got_v, got_v);
            mismatch_count++;
        end
    endtask

    // Sample both handshakes at the falling edge ahead of the rising edge that takes them
    always @(negedge aclk) begin
        in_xfer_n  = s_tvalid && s_tready && aresetn;
        out_xfer_n = m_tvalid && m_tready && aresetn;
        out_data_n = m_tdata;
    end

    // Receiver backpressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Check each result transfer and watch for a stuck stream
    always @(posedge aclk) begin : result_check
        date_time_t want, got;
        if (out_xfer_n) begin
            got.utc_s   = out_data_n[31:0];
            got.local_s = out_data_n[63:32];
            got.year    = out_data_n[74:64];
            got.month   = out_data_n[78:75];
            got.mday    = out_data_n[83:79];
            got.hour    = out_data_n[88:84];
            got.minute  = out_data_n[94:89];
            got.second  = out_data_n[100:95];
            got.pad     = out_data_n[103:101];
            if (pending_dates.size() == 0) begin
                $display("%0t: result with none expected, actual 0x%0h", $time, out_data_n);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("utc_seconds", want.utc_s, got.utc_s);
                compare_field("local_seconds", want.local_s, got.local_s);
                compare_field("year", 32'(want.year), 32'(got.year));
                compare_field("month", 32'(want.month), 32'(got.month));
                compare_field("day", 32'(want.mday), 32'(got.mday));
                compare_field("hour", 32'(want.hour), 32'(got.hour));
                compare_field("minute", 32'(want.minute), 32'(got.minute));
                compare_field("second", 32'(want.second), 32'(got.second));
                compare_field("pad", 32'(want.pad), 32'(got.pad));
            end
        end
        if (in_xfer_n || out_xfer_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("ntp_seconds_to_local_date_time regression: fail");
            $finish;
        end
    end

    // Offer one timestamp and hold it until the block takes it
    task automatic send_seconds(input logic [SECS_W-1:0] secs);
        logic ready_seen;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        ready_seen = 1'b0;
        while (!ready_seen) begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end
        pending_dates.push_back(local_date_time(secs, zone_code));
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_dates.size() != 0);
    endtask

    task automatic write_zone(input logic [ZONE_W-1:0] code);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        zone_code  = code;
        @(posedge aclk);
    endtask

    function automatic logic [ZONE_W-1:0] pick_zone();
        case ($urandom_range(7))
            0:       return ZONE_UTC_M1200;
            1:       return ZONE_TOP_CODE;
            2, 3, 4: return ZONE_W'($urandom_range(ZONE_COUNT - 1));
            default: return ZONE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [SECS_W-1:0] pick_seconds();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $urandom_range(100000);
            2:       return 32'hFFFF_FFFF - $urandom_range(100000);
            3:       return $urandom_range(49710) * SECS_PER_DAY - 1;
            default: return $urandom_range(49710) * SECS_PER_DAY + $urandom_range(59);
        endcase
    endfunction

    // Reset zone is UTC-12:00, so small counts wrap to the top of the range
    task automatic test_reset_zone();
        send_seconds(32'd0);
        send_seconds(32'd43199);
        send_seconds(32'd43200);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'h8000_0000);
    endtask

    // Codes with no offset, inside and beyond the zone table
    task automatic test_zero_offset_codes();
        write_zone(ZONE_UTC_A);
        send_seconds(32'd0);
        send_seconds(32'hFFFF_FFFF);
        write_zone(ZONE_UTC_B);
        send_seconds(32'd12345678);
        write_zone(ZONE_TOP_CODE);
        send_seconds(32'd0);
        write_zone(ZONE_PAST_END);
        send_seconds(32'hFFFF_FFFF);
    endtask

    // Positive offsets carried past 2^32, plus the odd quarter-hour zones
    task automatic test_offset_wrap();
        write_zone(ZONE_UTC_P1400);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'hFFFF_3B1F);
        send_seconds(32'hFFFF_3B20);
        write_zone(ZONE_UTC_P1245);
        send_seconds(32'd1000);
        write_zone(ZONE_UTC_P0545);
        send_seconds(32'd5000);
    endtask

    // Year and February ends around leap and century years
    task automatic test_leap_year_ends();
        write_zone(ZONE_UTC_A);
        send_seconds(32'd157766399);    // 1904-12-31 23:59:59
        send_seconds(32'd157766400);
        send_seconds(32'd3187295999);   // 2000-12-31 23:59:59
        send_seconds(32'd3160771200);   // 2000-02-29
        send_seconds(32'd5097599);      // 1900 has no Feb 29
        send_seconds(32'd5097600);
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0)
                write_zone(pick_zone());
            else if ($urandom_range(29) == 0)
                wait_for_results();
            send_seconds(pick_seconds());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 12;
        rx_idle_pct = 56;
        test_reset_zone();
        test_zero_offset_codes();
        test_offset_wrap();
        test_leap_year_ends();

        test_random_traffic(130, 12, 56);
        test_random_traffic(130, 56, 12);
        test_random_traffic(130, 0, 0);

        // drain, then wait out a tail of TAIL_CYCLES for stray results
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("ntp_seconds_to_local_date_time regression: pass");
        else
            $display("ntp_seconds_to_local_date_time regression: fail");
        $finish;
    end

endmodule

>>> ntp_seconds_to_local_date_time.f
rtl/ntpdt_pkg.sv
rtl/ntp_seconds_to_local_date_time.sv
rtl/ntpdt_checker.sv
sim/ntp_seconds_to_local_date_time_tb.sv
